### src/hlte_pkg.sv
// Shared constants, types and coefficient helpers for the heater lag temperature estimator.
`timescale 1ns / 1ps

package hlte_pkg;

    // Default heat-up limit in whole seconds
    localparam int unsigned HEAT_LIMIT_DEF = 60;

    // Field widths
    localparam int unsigned MODE_W = 2;
    localparam int unsigned TIME_W = 32;
    localparam int unsigned RAW_W  = 12;
    localparam int unsigned TEMP_W = 18;
    localparam int unsigned HEAT_W = 22;
    localparam int unsigned IN_W   = 48;
    localparam int unsigned OUT_W  = 24;

    // Datapath widths
    localparam int unsigned ACC_W   = 56;  // curve accumulator, units of 2^-38 degree
    localparam int unsigned CLAMP_W = 34;  // heat accumulator before clamping
    localparam int unsigned SECS_W  = 13;  // whole heat seconds of a 22-bit count
    localparam int unsigned D_W     = 14;  // curve difference in whole degrees
    localparam int unsigned PROD_W  = SECS_W + D_W + 1;
    localparam int unsigned DIV_W   = 25;  // magnitude of seconds times difference
    localparam int unsigned RCP_W   = DIV_W + 2;  // reciprocal of the heat-up limit
    localparam int unsigned CNT_W   = 2;   // Horner step counter
    localparam int unsigned UPSH_W  = ACC_W - 34;
    localparam int unsigned EST_W   = 33;

    // Shift amounts
    localparam int unsigned CURVE_SH = 38;
    localparam int unsigned OUT_SH   = 34;

    // Exact reciprocal of 1000 for any 22-bit count: floor(n * RECIP / 2^32)
    localparam int unsigned RECIP_W  = 23;
    localparam int unsigned RECIP_SH = 32;
    localparam logic [RECIP_W-1:0] RECIP_1000 = 23'd4294968;

    // Horner steps of the cubic curves
    localparam logic [1:0] HORN_LAST = 2'd2;

    // Up curve: C3, 4*C2, 16*C1 with 32 fractional bits
    localparam logic signed [ACC_W-1:0] UP_K3 = -56'sd13181;
    localparam logic signed [ACC_W-1:0] UP_K2 = 56'sd8589936;
    localparam logic signed [ACC_W-1:0] UP_K1 = 56'sd79274788368;

    // Difference curve (up minus down), same scaling
    localparam logic signed [ACC_W-1:0] DF_K3 = -56'sd33797;
    localparam logic signed [ACC_W-1:0] DF_K2 = 56'sd30923764;
    localparam logic signed [ACC_W-1:0] DF_K1 = 56'sd14692224128;

    // Output saturation bounds in 1/16 degree
    localparam logic signed [EST_W-1:0] EST_MIN = -33'sd32768;
    localparam logic signed [EST_W-1:0] EST_MAX = 33'sd98303;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic             accept_heat;
        logic             accept_sample;
        logic             horn;
        logic [1:0]       horn_idx;
        logic             prep;
        logic             mult;
        logic             div;
        logic             fin;
        logic             out_load;
    } t_dp_cmd;

    // Horner addend for the up curve after each multiply
    function automatic logic signed [ACC_W-1:0] up_addend(input logic [1:0] idx);
        logic signed [ACC_W-1:0] k;
        case (idx)
            2'd0:    k = UP_K2;
            2'd1:    k = UP_K1;
            default: k = '0;
        endcase
        return k;
    endfunction

    // Horner addend for the difference curve after each multiply
    function automatic logic signed [ACC_W-1:0] df_addend(input logic [1:0] idx);
        logic signed [ACC_W-1:0] k;
        case (idx)
            2'd0:    k = DF_K2;
            2'd1:    k = DF_K1;
            default: k = '0;
        endcase
        return k;
    endfunction

endpackage

### src/hlte_ctrl.sv
// Controller state machine that sequences heater commands and sample evaluation.
`timescale 1ns / 1ps

module hlte_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_axis_tvalid,
    input  logic            i_s_axis_tuser,
    input  logic            i_m_axis_tready,
    output logic            o_s_axis_tready,
    output logic            o_m_axis_tvalid,
    output hlte_pkg::t_dp_cmd o_cmd
);
    import hlte_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HORN,
        S_PREP,
        S_MUL,
        S_DIV,
        S_FIN,
        S_OUT
    } t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_cnt;
    logic             r_out_valid;
    logic             in_beat;
    logic             out_free;

    // Handshake decode
    assign in_beat         = (r_state == S_IDLE) && i_s_axis_tvalid;
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;

    // Datapath commands follow the state
    always_comb begin
        o_cmd               = '0;
        o_cmd.accept_heat   = in_beat && !i_s_axis_tuser;
        o_cmd.accept_sample = in_beat && i_s_axis_tuser;
        o_cmd.horn          = (r_state == S_HORN);
        o_cmd.horn_idx      = r_cnt[1:0];
        o_cmd.prep          = (r_state == S_PREP);
        o_cmd.mult          = (r_state == S_MUL);
        o_cmd.div           = (r_state == S_DIV);
        o_cmd.fin           = (r_state == S_FIN);
        o_cmd.out_load      = (r_state == S_OUT) && out_free;
    end

    // State, step counter and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_cnt <= '0;
                    if (in_beat) begin
                        r_state <= i_s_axis_tuser ? S_HORN : S_OUT;
                    end
                end
                S_HORN: begin
                    if (r_cnt[1:0] == HORN_LAST) begin
                        r_cnt   <= '0;
                        r_state <= S_PREP;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_PREP: begin
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### src/hlte_dpath.sv
// Datapath: heat-time accumulator, Horner curve unit, divider and output register.
`timescale 1ns / 1ps

module hlte_dpath #(
    parameter int unsigned HEAT_LIMIT_SECONDS = hlte_pkg::HEAT_LIMIT_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  hlte_pkg::t_dp_cmd          i_cmd,
    input  logic [hlte_pkg::IN_W-1:0]  i_s_axis_tdata,
    output logic [hlte_pkg::OUT_W-1:0] o_m_axis_tdata
);
    import hlte_pkg::*;

    // Reciprocal of the limit, exact for any dividend below 2^DIV_W
    localparam int unsigned QUO_SH = DIV_W + $clog2(HEAT_LIMIT_SECONDS);
    localparam logic [RCP_W-1:0] LIM_RCP = RCP_W'(((64'd1 << QUO_SH)
        + 64'(HEAT_LIMIT_SECONDS) - 64'd1) / 64'(HEAT_LIMIT_SECONDS));
    localparam logic signed [CLAMP_W-1:0] HEAT_TOP = CLAMP_W'(HEAT_LIMIT_SECONDS * 1000);

    // Input fields
    logic [MODE_W-1:0] in_mode;
    logic [TIME_W-1:0] in_now;
    logic [RAW_W-1:0]  in_raw;

    assign in_mode = i_s_axis_tdata[MODE_W-1:0];
    assign in_now  = i_s_axis_tdata[MODE_W+TIME_W-1:MODE_W];
    assign in_raw  = i_s_axis_tdata[MODE_W+TIME_W+RAW_W-1:MODE_W+TIME_W];

    // Heater state
    logic              r_heater_active;
    logic [TIME_W-1:0] r_last_time;
    logic [HEAT_W-1:0] r_heat_ms;
    logic [MODE_W-1:0] r_drive;

    // Sample pipeline registers
    logic [RAW_W-1:0]               r_raw;
    logic signed [ACC_W-1:0]        r_acc_up;
    logic signed [ACC_W-1:0]        r_acc_df;
    logic signed [UPSH_W-1:0]       r_up_sh;
    logic signed [D_W-1:0]          r_d;
    logic [SECS_W-1:0]              r_secs;
    logic                           r_neg;
    logic [DIV_W-1:0]               r_quo;
    logic signed [TEMP_W-1:0]       r_res_temp;
    logic [MODE_W-1:0]              r_res_drive;
    logic [OUT_W-1:0]               r_out;

    // Heat accumulator update for a heater command
    logic [TIME_W-1:0]         elapsed;
    logic signed [CLAMP_W-1:0] heat_sum;
    logic [HEAT_W-1:0]         n_heat_ms;

    always_comb begin
        elapsed = in_now - r_last_time;
        if (r_heater_active) begin
            heat_sum = signed'(CLAMP_W'(r_heat_ms)) + signed'(CLAMP_W'(elapsed));
        end else begin
            heat_sum = signed'(CLAMP_W'(r_heat_ms)) - signed'(CLAMP_W'(elapsed));
        end
        if (heat_sum < 0) begin
            n_heat_ms = '0;
        end else if (heat_sum > HEAT_TOP) begin
            n_heat_ms = HEAT_TOP[HEAT_W-1:0];
        end else begin
            n_heat_ms = heat_sum[HEAT_W-1:0];
        end
    end

    // One Horner step on both curves: acc * r + k
    logic signed [RAW_W:0]       raw_s;
    logic signed [ACC_W+RAW_W:0] prod_up;
    logic signed [ACC_W+RAW_W:0] prod_df;
    logic signed [ACC_W-1:0]     n_acc_up;
    logic signed [ACC_W-1:0]     n_acc_df;

    always_comb begin
        raw_s    = signed'({1'b0, r_raw});
        prod_up  = r_acc_up * raw_s;
        prod_df  = r_acc_df * raw_s;
        n_acc_up = signed'(prod_up[ACC_W-1:0]) + up_addend(i_cmd.horn_idx);
        n_acc_df = signed'(prod_df[ACC_W-1:0]) + df_addend(i_cmd.horn_idx);
    end

    // Whole-degree difference, truncated toward zero, and whole heat seconds
    logic signed [ACC_W-1:0]       df_bias;
    logic [HEAT_W+RECIP_W-1:0]     secs_prod;

    always_comb begin
        df_bias   = r_acc_df + (r_acc_df < 0 ? ACC_W'((64'd1 << CURVE_SH) - 64'd1) : '0);
        secs_prod = HEAT_W'(r_heat_ms) * RECIP_1000;
    end

    // Seconds times difference, split into sign and magnitude
    logic signed [PROD_W-1:0] sd_prod;
    logic signed [PROD_W-1:0] sd_mag;

    always_comb begin
        sd_prod = signed'({1'b0, r_secs}) * r_d;
        sd_mag  = (sd_prod < 0) ? -sd_prod : sd_prod;
    end

    // Quotient of the magnitude by the heat-up limit via reciprocal multiply
    logic [DIV_W+RCP_W-1:0] quo_prod;
    logic [DIV_W-1:0]       n_quo;

    always_comb begin
        quo_prod = r_quo * LIM_RCP;
        n_quo    = DIV_W'(quo_prod >> QUO_SH);
    end

    // Final estimate: floor(up) in 1/16 degree minus 16*q, saturated
    logic signed [DIV_W:0]   q_s;
    logic signed [EST_W-1:0] est;
    logic signed [TEMP_W-1:0] est_sat;

    always_comb begin
        q_s = signed'({1'b0, r_quo});
        if (r_neg) begin
            q_s = -q_s;
        end
        est = EST_W'(r_up_sh) - (EST_W'(q_s) <<< 4);
        if (est < EST_MIN) begin
            est_sat = EST_MIN[TEMP_W-1:0];
        end else if (est > EST_MAX) begin
            est_sat = EST_MAX[TEMP_W-1:0];
        end else begin
            est_sat = est[TEMP_W-1:0];
        end
    end

    // Heater state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heater_active <= 1'b0;
            r_last_time     <= '0;
            r_heat_ms       <= '0;
            r_drive         <= '0;
        end else if (i_cmd.accept_heat) begin
            r_heater_active <= (in_mode != '0);
            r_last_time     <= in_now;
            r_heat_ms       <= n_heat_ms;
            r_drive         <= in_mode;
        end
    end

    // Sample evaluation and result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept_heat) begin
            r_res_temp  <= '0;
            r_res_drive <= in_mode;
        end
        if (i_cmd.accept_sample) begin
            r_raw    <= in_raw;
            r_acc_up <= UP_K3;
            r_acc_df <= DF_K3;
        end
        if (i_cmd.horn) begin
            r_acc_up <= n_acc_up;
            r_acc_df <= n_acc_df;
        end
        if (i_cmd.prep) begin
            r_up_sh <= r_acc_up[ACC_W-1:OUT_SH];
            r_d     <= df_bias[CURVE_SH+D_W-1:CURVE_SH];
            r_secs  <= secs_prod[RECIP_SH+SECS_W-1:RECIP_SH];
        end
        if (i_cmd.mult) begin
            r_neg <= (sd_prod < 0);
            r_quo <= sd_mag[DIV_W-1:0];
        end
        if (i_cmd.div) begin
            r_quo <= n_quo;
        end
        if (i_cmd.fin) begin
            r_res_temp  <= est_sat;
            r_res_drive <= r_drive;
        end
        if (i_cmd.out_load) begin
            r_out <= {{(OUT_W - TEMP_W - 2){1'b0}}, r_res_temp, r_res_drive[0], r_res_drive[1]};
        end
    end

    assign o_m_axis_tdata = r_out;

endmodule

### src/heater_lag_temp_estimator.sv
// Top level of the heater lag temperature estimator.
`timescale 1ns / 1ps

// Heater lag temperature estimator.
// Input stream: one beat per item. s_axis_tuser selects the kind: 0 is a heater
// command (mode and millisecond time stamp), 1 is a thermocouple sample.
// Output stream: one beat per input beat with both drive levels and the
// compensated temperature in 1/16 degree (zero for heater commands).
// A heater command updates the heat-time accumulator and the drive levels at
// the accept edge; its result is loaded into the output register in the output
// state once that register is free; the input is ready again after the load.
// A sample runs three Horner steps on the up and difference curves, a step for
// whole degrees and seconds, a multiply, a reciprocal multiply by the heat-up
// limit and a final subtract and saturate. Its result is loaded from the
// output state once the output register is free, and the next item can be
// taken after that load; the input is not ready while a sample is in work.
// The output beat sits in a register: the next item is accepted while it
// waits, and that item's result is held back until the receiver takes it.
// Reset (synchronous, active low) clears the accumulator, the time stamp and
// both drive levels and empties the output register.
module heater_lag_temp_estimator #(
    parameter int unsigned HEAT_LIMIT_SECONDS = hlte_pkg::HEAT_LIMIT_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // tdata, low bit up: heater_mode[1:0], now_ms[33:2], thermo_raw[45:34], zeros
    input  logic [hlte_pkg::IN_W-1:0]  i_s_axis_tdata,
    // tuser: command (0 heater command, 1 sample)
    input  logic                       i_s_axis_tuser,
    output logic                       o_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    // tdata, low bit up: heat_up_drive[0], heat_down_drive[1],
    // temp_estimate[19:2], zeros
    output logic [hlte_pkg::OUT_W-1:0] o_m_axis_tdata
);
    import hlte_pkg::*;

    t_dp_cmd dp_cmd;

    hlte_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_m_axis_tready (i_m_axis_tready),
        .o_s_axis_tready (o_s_axis_tready),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .o_cmd           (dp_cmd)
    );

    hlte_dpath #(
        .HEAT_LIMIT_SECONDS (HEAT_LIMIT_SECONDS)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .i_s_axis_tdata (i_s_axis_tdata),
        .o_m_axis_tdata (o_m_axis_tdata)
    );

endmodule
